@@ hdl/c8x_pkg.sv @@
package c8x_pkg;

  localparam int MEM_BYTES_DEF = 4096;
  localparam int REG_COUNT_DEF = 16;
  localparam int AW = 12;

  localparam logic [AW-1:0] PC_RESET    = 12'h200;
  localparam logic [AW-1:0] SP_RESET    = 12'hEA0;
  localparam logic [AW-1:0] SCREEN_LO   = 12'hF00;
  localparam logic [AW-1:0] SCREEN_HI   = 12'hFFF;
  localparam logic [7:0]    TIMER_RESET = 8'hFF;

  localparam logic [1:0] ACT_LOAD = 2'd0;
  localparam logic [1:0] ACT_EXEC = 2'd1;
  localparam logic [1:0] ACT_READ = 2'd2;
  localparam logic [1:0] ACT_NONE = 2'd3;

  // datapath commands
  localparam logic [3:0] CMD_NONE    = 4'd0;
  localparam logic [3:0] CMD_LOAD    = 4'd1;
  localparam logic [3:0] CMD_READ    = 4'd2;
  localparam logic [3:0] CMD_FETCH0  = 4'd3;
  localparam logic [3:0] CMD_FETCH1  = 4'd4;
  localparam logic [3:0] CMD_DECODE  = 4'd5;
  localparam logic [3:0] CMD_EXEC    = 4'd6;
  localparam logic [3:0] CMD_CLEAR   = 4'd7;
  localparam logic [3:0] CMD_RET0    = 4'd8;
  localparam logic [3:0] CMD_RET1    = 4'd9;
  localparam logic [3:0] CMD_RET2    = 4'd10;
  localparam logic [3:0] CMD_CALL1   = 4'd11;
  localparam logic [3:0] CMD_STORE   = 4'd12;
  localparam logic [3:0] CMD_LDREG   = 4'd13;
  localparam logic [3:0] CMD_LDREG_W = 4'd14;
  localparam logic [3:0] CMD_INIT    = 4'd15;

  // instruction classes resolved at decode
  localparam logic [2:0] CLS_SIMPLE  = 3'd0;
  localparam logic [2:0] CLS_CLEAR   = 3'd1;
  localparam logic [2:0] CLS_RET     = 3'd2;
  localparam logic [2:0] CLS_CALL    = 3'd3;
  localparam logic [2:0] CLS_STORE   = 3'd4;
  localparam logic [2:0] CLS_LOADR   = 3'd5;
  localparam logic [2:0] CLS_INVALID = 3'd6;

  typedef struct packed {
    logic [3:0] cmd;
    logic       start;
  } c8x_ctl_t;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] cls;
    logic       sweep_last;
  } c8x_sts_t;

endpackage

@@ hdl/c8x_ctrl.sv @@
module c8x_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  c8x_pkg::c8x_sts_t sts,
  output c8x_pkg::c8x_ctl_t ctl
);
  import c8x_pkg::*;

  localparam logic [3:0] S_INIT   = 4'd0;
  localparam logic [3:0] S_IDLE   = 4'd1;
  localparam logic [3:0] S_F0     = 4'd2;
  localparam logic [3:0] S_F1     = 4'd3;
  localparam logic [3:0] S_DEC    = 4'd4;
  localparam logic [3:0] S_EXEC   = 4'd5;
  localparam logic [3:0] S_CLEAR  = 4'd6;
  localparam logic [3:0] S_RET0   = 4'd7;
  localparam logic [3:0] S_RET1   = 4'd8;
  localparam logic [3:0] S_RET2   = 4'd9;
  localparam logic [3:0] S_CALL1  = 4'd10;
  localparam logic [3:0] S_STORE  = 4'd11;
  localparam logic [3:0] S_LDREG  = 4'd12;
  localparam logic [3:0] S_LDREGW = 4'd13;
  localparam logic [3:0] S_DONE   = 4'd14;
  localparam logic [3:0] S_GO     = 4'd15;

  logic [3:0] state, state_next;
  logic       out_valid_next;

  assign in_ready = (state == S_IDLE) && (!out_valid || out_ready);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid && !out_ready;
    ctl.cmd        = CMD_NONE;
    ctl.start      = 1'b0;
    case (state)
      S_INIT: begin
        ctl.cmd = CMD_INIT;
        if (sts.sweep_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid && in_ready) begin
          ctl.start = 1'b1;
          state_next = S_GO;
        end
      end
      S_GO: begin
        case (sts.action)
          ACT_LOAD: begin
            ctl.cmd = CMD_LOAD;
            state_next = S_DONE;
          end
          ACT_READ: begin
            ctl.cmd = CMD_READ;
            state_next = S_F1;
          end
          ACT_EXEC: begin
            ctl.cmd = CMD_FETCH0;
            state_next = S_F0;
          end
          default: state_next = S_DONE;
        endcase
      end
      S_F0: begin
        ctl.cmd = CMD_FETCH1;
        state_next = S_F1;
      end
      S_F1: begin
        // read action finishes here after its data arrives
        if (sts.action == ACT_READ) begin
          ctl.cmd = CMD_DECODE;
          state_next = S_DONE;
        end else begin
          ctl.cmd = CMD_DECODE;
          state_next = S_DEC;
        end
      end
      S_DEC: begin
        ctl.cmd = CMD_EXEC;
        case (sts.cls)
          CLS_CLEAR: state_next = S_CLEAR;
          CLS_RET:   state_next = S_RET0;
          CLS_CALL:  state_next = S_CALL1;
          CLS_STORE: state_next = S_STORE;
          CLS_LOADR: state_next = S_LDREG;
          default:   state_next = S_DONE;
        endcase
      end
      S_CLEAR: begin
        ctl.cmd = CMD_CLEAR;
        if (sts.sweep_last) state_next = S_DONE;
      end
      S_RET0: begin
        ctl.cmd = CMD_RET0;
        state_next = S_RET1;
      end
      S_RET1: begin
        ctl.cmd = CMD_RET1;
        state_next = S_RET2;
      end
      S_RET2: begin
        ctl.cmd = CMD_RET2;
        state_next = S_DONE;
      end
      S_CALL1: begin
        ctl.cmd = CMD_CALL1;
        state_next = S_DONE;
      end
      S_STORE: begin
        ctl.cmd = CMD_STORE;
        if (sts.sweep_last) state_next = S_DONE;
      end
      S_LDREG: begin
        ctl.cmd = CMD_LDREG;
        state_next = S_LDREGW;
      end
      S_LDREGW: begin
        ctl.cmd = CMD_LDREG_W;
        state_next = sts.sweep_last ? S_DONE : S_LDREG;
      end
      S_DONE: begin
        out_valid_next = 1'b1;
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_INIT;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");
  assert property (@(posedge clk) disable iff (rst)
    in_ready |-> state == S_IDLE)
    else $error("item accepted outside idle");
  assert property (@(posedge clk) disable iff (rst)
    state == S_DONE |=> out_valid)
    else $error("finished item not presented");
endmodule

@@ hdl/c8x_datapath.sv @@
module c8x_datapath #(
  parameter int MEM_BYTES = c8x_pkg::MEM_BYTES_DEF,
  parameter int REG_COUNT = c8x_pkg::REG_COUNT_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  c8x_pkg::c8x_ctl_t ctl,
  output c8x_pkg::c8x_sts_t sts,
  input  logic [1:0]        action,
  input  logic [11:0]       mem_address,
  input  logic [7:0]        mem_data,
  output logic              ok,
  output logic [11:0]       program_counter,
  output logic [11:0]       index_value,
  output logic [7:0]        delay_value,
  output logic [7:0]        sound_value,
  output logic [7:0]        read_data
);
  import c8x_pkg::*;

  localparam int MAW = $clog2(MEM_BYTES);
  localparam int RW  = $clog2(REG_COUNT);

  logic [7:0]  mem [MEM_BYTES];
  logic [7:0]  regs [REG_COUNT];
  logic [7:0]  mem_rd;
  logic [MAW-1:0] rd_addr;
  logic        wr_en;
  logic [MAW-1:0] wr_addr;
  logic [7:0]  wr_data;

  logic [1:0]  act;
  logic [11:0] addr_q;
  logic [7:0]  data_q;
  logic [15:0] op;
  logic [7:0]  hi_q;
  logic [11:0] pc, ireg, sp;
  logic [7:0]  dly, snd;
  logic [2:0]  cls;
  logic [RW-1:0] cnt;
  logic [MAW-1:0] sweep;

  logic [3:0]  top, ox, oy, on;
  logic [7:0]  nn;
  logic [11:0] nnn, pc_next2, pc_skip;
  logic [7:0]  vx, vy;

  assign top = op[15:12];
  assign ox  = op[11:8];
  assign oy  = op[7:4];
  assign on  = op[3:0];
  assign nn  = op[7:0];
  assign nnn = op[11:0];
  assign pc_next2 = pc + 12'd2;
  assign pc_skip  = pc + 12'd4;
  assign vx = regs[ox[RW-1:0]];
  assign vy = regs[oy[RW-1:0]];

  // classify the fetched word (op register holds it after decode)
  logic [2:0] cls_c;
  logic       valid_c;
  always_comb begin
    cls_c = CLS_SIMPLE;
    case (top)
      4'h0: begin
        if (op == 16'h00E0) cls_c = CLS_CLEAR;
        else if (op == 16'h00EE) cls_c = CLS_RET;
        else cls_c = CLS_INVALID;
      end
      4'h2: cls_c = CLS_CALL;
      4'h5, 4'h9: if (on != 4'h0) cls_c = CLS_INVALID;
      4'h8: begin
        if (!(on <= 4'h7 || on == 4'hE)) cls_c = CLS_INVALID;
      end
      4'hE: if (nn != 8'h9E && nn != 8'hA1) cls_c = CLS_INVALID;
      4'hF: begin
        case (nn)
          8'h55: cls_c = CLS_STORE;
          8'h65: cls_c = CLS_LOADR;
          8'h07, 8'h0A, 8'h15, 8'h18, 8'h1E, 8'h29, 8'h33: cls_c = CLS_SIMPLE;
          default: cls_c = CLS_INVALID;
        endcase
      end
      default: cls_c = CLS_SIMPLE;
    endcase
    valid_c = (cls_c != CLS_INVALID);
  end

  // class of the word held in op, valid from decode to the end of the item
  assign cls = cls_c;

  assign sts.action     = act;
  assign sts.cls        = cls;
  assign sts.sweep_last = (ctl.cmd == CMD_INIT && sweep == MAW'(MEM_BYTES - 1)) ||
                          (ctl.cmd == CMD_CLEAR && sweep == MAW'(SCREEN_HI)) ||
                          (ctl.cmd == CMD_STORE && cnt == ox[RW-1:0]) ||
                          (ctl.cmd == CMD_LDREG_W && cnt == ox[RW-1:0]);

  // memory port selection
  always_comb begin
    rd_addr = MAW'(pc);
    wr_en   = 1'b0;
    wr_addr = MAW'(addr_q);
    wr_data = data_q;
    case (ctl.cmd)
      CMD_READ:   rd_addr = MAW'(addr_q);
      CMD_FETCH0: rd_addr = MAW'(pc);
      CMD_FETCH1: rd_addr = MAW'(pc + 12'd1);
      CMD_RET0:   rd_addr = MAW'(sp - 12'd2);
      CMD_RET1:   rd_addr = MAW'(sp - 12'd1);
      CMD_LDREG:  rd_addr = MAW'(ireg);
      CMD_LOAD:   wr_en = 1'b1;
      CMD_INIT, CMD_CLEAR: begin
        wr_en = 1'b1;
        wr_addr = sweep;
        wr_data = 8'h00;
      end
      CMD_EXEC: begin
        if (cls == CLS_CALL) begin
          wr_en = 1'b1;
          wr_addr = MAW'(sp);
          wr_data = {4'h0, pc_next2[11:8]};
        end
      end
      CMD_CALL1: begin
        wr_en = 1'b1;
        wr_addr = MAW'(sp + 12'd1);
        wr_data = pc_next2[7:0];
      end
      CMD_STORE: begin
        wr_en = 1'b1;
        wr_addr = MAW'(ireg);
        wr_data = regs[cnt];
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_addr] <= wr_data;
    mem_rd <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= PC_RESET;
      ireg <= '0;
      sp <= SP_RESET;
      dly <= TIMER_RESET;
      snd <= TIMER_RESET;
      sweep <= '0;
      for (int i = 0; i < REG_COUNT; i++) regs[i] <= 8'h00;
    end else begin
      if (ctl.start) begin
        act <= action;
        addr_q <= mem_address;
        data_q <= mem_data;
        cnt <= '0;
        sweep <= MAW'(SCREEN_LO);
        read_data <= 8'h00;
        ok <= (action != ACT_NONE);
        if (action == ACT_EXEC) begin
          dly <= dly - 8'd1;
          snd <= snd - 8'd1;
        end
      end
      case (ctl.cmd)
        CMD_INIT: sweep <= sweep + MAW'(1);
        CMD_FETCH1: hi_q <= mem_rd;
        CMD_DECODE: begin
          if (act == ACT_READ) read_data <= mem_rd;
          else op <= {hi_q, mem_rd};
        end
        CMD_CLEAR: sweep <= sweep + MAW'(1);
        CMD_RET1: hi_q <= mem_rd;
        CMD_RET2: begin
          pc <= {hi_q[3:0], mem_rd};
          sp <= sp - 12'd2;
        end
        CMD_CALL1: begin
          sp <= sp + 12'd2;
          pc <= nnn;
        end
        CMD_STORE: begin
          ireg <= ireg + 12'd1;
          cnt <= cnt + RW'(1);
          if (cnt == ox[RW-1:0]) pc <= pc_next2;
        end
        CMD_LDREG_W: begin
          regs[cnt] <= mem_rd;
          ireg <= ireg + 12'd1;
          cnt <= cnt + RW'(1);
          if (cnt == ox[RW-1:0]) pc <= pc_next2;
        end
        CMD_EXEC: begin
          ok <= valid_c;
          case (top)
            4'h0: if (cls == CLS_CLEAR) pc <= pc_next2;
            4'h1: pc <= nnn;
            4'h3: pc <= (vx == nn) ? pc_skip : pc_next2;
            4'h4: pc <= (vx != nn) ? pc_skip : pc_next2;
            4'h5: if (valid_c) pc <= (vx == vy) ? pc_skip : pc_next2;
            4'h9: if (valid_c) pc <= (vx != vy) ? pc_skip : pc_next2;
            4'h6: begin
              regs[ox[RW-1:0]] <= nn;
              pc <= pc_next2;
            end
            4'h7: begin
              regs[ox[RW-1:0]] <= vx + nn;
              pc <= pc_next2;
            end
            4'h8: begin
              if (valid_c) begin
                pc <= pc_next2;
                case (on)
                  4'h0: regs[ox[RW-1:0]] <= vy;
                  4'h1: regs[ox[RW-1:0]] <= vx | vy;
                  4'h2: regs[ox[RW-1:0]] <= vx & vy;
                  4'h3: regs[ox[RW-1:0]] <= vx ^ vy;
                  4'h4: begin
                    regs[ox[RW-1:0]] <= vx + vy;
                    regs[REG_COUNT-1] <= {7'd0, ({1'b0, vx} + {1'b0, vy}) > 9'h0FF};
                  end
                  4'h5: begin
                    regs[ox[RW-1:0]] <= vx - vy;
                    regs[REG_COUNT-1] <= {7'd0, vx >= vy};
                  end
                  4'h6: begin
                    regs[ox[RW-1:0]] <= {1'b0, vy[7:1]};
                    regs[REG_COUNT-1] <= {7'd0, vy[0]};
                  end
                  4'h7: begin
                    regs[ox[RW-1:0]] <= vy - vx;
                    regs[REG_COUNT-1] <= {7'd0, vy >= vx};
                  end
                  4'hE: begin
                    regs[ox[RW-1:0]] <= {vy[6:0], 1'b0};
                    regs[REG_COUNT-1] <= {7'd0, vy[7]};
                  end
                  default: ;
                endcase
              end
            end
            4'hA: begin
              ireg <= nnn;
              pc <= pc_next2;
            end
            4'hB: pc <= nnn + {4'h0, regs[0]};
            4'hF: begin
              case (nn)
                8'h07: begin
                  regs[ox[RW-1:0]] <= dly;
                  pc <= pc_next2;
                end
                8'h15: begin
                  dly <= vx;
                  pc <= pc_next2;
                end
                8'h18: begin
                  snd <= vx;
                  pc <= pc_next2;
                end
                8'h1E: begin
                  ireg <= ireg + {4'h0, vx};
                  pc <= pc_next2;
                end
                8'h29: begin
                  ireg <= {2'b00, vx, 2'b00} + {4'h0, vx};
                  pc <= pc_next2;
                end
                default: ;
              endcase
            end
            default: ;
          endcase
        end
        default: ;
      endcase
    end
  end

  assign program_counter = pc;
  assign index_value     = ireg;
  assign delay_value     = dly;
  assign sound_value     = snd;

  assert property (@(posedge clk) disable iff (rst)
    ctl.cmd == CMD_RET2 |=> sp == $past(sp) - 12'd2)
    else $error("return did not pop stack");
  assert property (@(posedge clk) disable iff (rst)
    ctl.cmd == CMD_CALL1 |=> sp == $past(sp) + 12'd2)
    else $error("call did not push stack");
  assert property (@(posedge clk) disable iff (rst)
    ctl.start && action == ACT_EXEC |=> dly == $past(dly) - 8'd1)
    else $error("delay timer not stepped");
endmodule

@@ hdl/chip8_instruction_executor.sv @@
// channel | signals                                            | handshake
// in      | action, mem_address, mem_data                      | in_valid / in_ready
// out     | ok, program_counter, index_value, delay_value,     | out_valid / out_ready
//         | sound_value, read_data                             |
// Clear screen walks 256 bytes, one per cycle; FX55 walks one register per cycle and
// FX65 reads, then writes, each register in turn, all through the one memory array.
// After reset the whole memory is zeroed; no item is taken meanwhile.
// A new item is taken only once the unit is idle and the last result has left,
// at the earliest in the cycle that result is accepted.
module chip8_instruction_executor #(
  parameter int MEM_BYTES = c8x_pkg::MEM_BYTES_DEF,
  parameter int REG_COUNT = c8x_pkg::REG_COUNT_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  action,
  input  logic [11:0] mem_address,
  input  logic [7:0]  mem_data,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        ok,
  output logic [11:0] program_counter,
  output logic [11:0] index_value,
  output logic [7:0]  delay_value,
  output logic [7:0]  sound_value,
  output logic [7:0]  read_data
);
  import c8x_pkg::*;

  c8x_ctl_t ctl;
  c8x_sts_t sts;

  c8x_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_ready, .out_valid, .out_ready, .sts, .ctl
  );

  c8x_datapath #(.MEM_BYTES(MEM_BYTES), .REG_COUNT(REG_COUNT)) u_dp (
    .clk, .rst, .ctl, .sts, .action, .mem_address, .mem_data, .ok,
    .program_counter, .index_value, .delay_value, .sound_value, .read_data
  );
endmodule
